/* rtl/rbs_pkg.sv */
// shared types, widths and constants for the ray / box slab test
package rbs_pkg;

  // coordinate width; the fixed-point scale cancels in every ratio
  localparam int COORD_BITS = 16;
  localparam int AXES       = 3;
  localparam int OFF_BITS   = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * OFF_BITS;
  localparam int PAIRS      = AXES * (AXES - 1);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [OFF_BITS-1:0]   off_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic [1:0]                   axis_t;
  typedef logic [AXES-1:0]              axis_mask_t;

  // ordered axis pairs (i, j) with i != j
  localparam axis_t PAIR_I [PAIRS] = '{2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
  localparam axis_t PAIR_J [PAIRS] = '{2'd1, 2'd2, 2'd0, 2'd2, 2'd0, 2'd1};

  // request payload
  typedef struct packed {
    coord_t ray_origin_x;
    coord_t ray_origin_y;
    coord_t ray_origin_z;
    coord_t ray_dir_x;
    coord_t ray_dir_y;
    coord_t ray_dir_z;
    coord_t box_min_x;
    coord_t box_min_y;
    coord_t box_min_z;
    coord_t box_max_x;
    coord_t box_max_y;
    coord_t box_max_z;
  } ray_box_t;

  // result payload
  typedef struct packed {
    logic hits_box;
  } hit_t;

  // per-axis slab interval as numerators over a positive denominator
  typedef struct packed {
    off_t [AXES-1:0] lo_n;
    off_t [AXES-1:0] hi_n;
    off_t [AXES-1:0] den;
    axis_mask_t      unbounded;
    logic            miss;
  } slab_t;

  // cross products for every ordered axis pair
  typedef struct packed {
    prod_t [PAIRS-1:0] near_p;
    prod_t [PAIRS-1:0] far_p;
    axis_mask_t        unbounded;
    logic              miss;
  } cross_t;

endpackage

/* rtl/rbs_req_if.sv */
// request channel: one ray and one box per request
interface rbs_req_if import rbs_pkg::*; ();
  logic     valid;
  logic     ready;
  ray_box_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/rbs_rsp_if.sv */
// response channel: one hit flag per request
interface rbs_rsp_if import rbs_pkg::*; ();
  logic valid;
  logic ready;
  hit_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/rbs_slab.sv */
// stage 1: per-axis plane offsets, denominators and zero-direction checks
module rbs_slab import rbs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  ray_box_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output slab_t    out_data
);

  coord_t org  [AXES];
  coord_t dir  [AXES];
  coord_t bmin [AXES];
  coord_t bmax [AXES];
  slab_t  slab_next;

  // stage advances when empty or when the next stage takes its request
  assign in_ready = !out_valid || out_ready;

  always_comb begin
    org[0]  = in_data.ray_origin_x;
    org[1]  = in_data.ray_origin_y;
    org[2]  = in_data.ray_origin_z;
    dir[0]  = in_data.ray_dir_x;
    dir[1]  = in_data.ray_dir_y;
    dir[2]  = in_data.ray_dir_z;
    bmin[0] = in_data.box_min_x;
    bmin[1] = in_data.box_min_y;
    bmin[2] = in_data.box_min_z;
    bmax[0] = in_data.box_max_x;
    bmax[1] = in_data.box_max_y;
    bmax[2] = in_data.box_max_z;
  end

  // offsets to the near and far planes; planes swap for a negative direction
  always_comb begin
    slab_next = '0;
    for (int i = 0; i < AXES; i++) begin
      if (dir[i] == '0) begin
        slab_next.den[i] = off_t'(1);
        if (bmin[i] <= org[i] && org[i] <= bmax[i]) begin
          slab_next.unbounded[i] = 1'b1;
        end else begin
          slab_next.miss = 1'b1;
        end
      end else if (dir[i][COORD_BITS-1]) begin
        slab_next.lo_n[i] = off_t'(org[i]) - off_t'(bmax[i]);
        slab_next.hi_n[i] = off_t'(org[i]) - off_t'(bmin[i]);
        slab_next.den[i]  = -off_t'(dir[i]);
      end else begin
        slab_next.lo_n[i] = off_t'(bmin[i]) - off_t'(org[i]);
        slab_next.hi_n[i] = off_t'(bmax[i]) - off_t'(org[i]);
        slab_next.den[i]  = off_t'(dir[i]);
      end
    end
  end

  // valid register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= slab_next;
    end
  end

endmodule

/* rtl/rbs_cross.sv */
// stage 2: cross multiplication of interval bounds for every axis pair
module rbs_cross import rbs_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  slab_t  in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output cross_t out_data
);

  cross_t cross_next;

  assign in_ready = !out_valid || out_ready;

  // lo_i > hi_j compares as lo_n[i]*den[j] > hi_n[j]*den[i]
  always_comb begin
    cross_next           = '0;
    cross_next.unbounded = in_data.unbounded;
    cross_next.miss      = in_data.miss;
    for (int k = 0; k < PAIRS; k++) begin
      cross_next.near_p[k] = prod_t'($signed(in_data.lo_n[PAIR_I[k]]))
                           * prod_t'($signed(in_data.den[PAIR_J[k]]));
      cross_next.far_p[k]  = prod_t'($signed(in_data.hi_n[PAIR_J[k]]))
                           * prod_t'($signed(in_data.den[PAIR_I[k]]));
    end
  end

  // valid register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= cross_next;
    end
  end

endmodule

/* rtl/rbs_decide.sv */
// stage 3: pairwise interval compares and the registered hit flag
module rbs_decide import rbs_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  cross_t in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output hit_t   out_data
);

  logic [PAIRS-1:0] beyond;
  hit_t             hit_next;

  assign in_ready = !out_valid || out_ready;

  // a pair separates when neither axis is unbounded and one interval passes the other
  always_comb begin
    for (int k = 0; k < PAIRS; k++) begin
      beyond[k] = !in_data.unbounded[PAIR_I[k]] && !in_data.unbounded[PAIR_J[k]]
                && ($signed(in_data.near_p[k]) > $signed(in_data.far_p[k]));
    end
    hit_next.hits_box = !in_data.miss && (beyond == '0);
  end

  // output valid register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= hit_next;
    end
  end

endmodule

/* rtl/ray_box_slab_test.sv */
// top level of the ray / axis-aligned box slab test pipeline
//
// ray: request channel, one ray origin, ray direction and box corners per
//   request, all signed fixed point of COORD_BITS bits.
// result: response channel, one hits_box flag per request, in request order.
// A request is taken on a clock edge where valid and ready are both high.
// Each result passes three pipeline registers after acceptance: plane offsets,
// cross products of the interval bounds, then the compares feeding the output
// register. Throughput is one request per cycle unless the receiver stalls;
// the three pipeline registers each hold one request, so up to three are in flight.
// When the receiver holds ready low, the output register keeps its result
// and earlier stages keep filling empty slots; ray.ready drops only once
// every stage holds a request. Nothing is dropped or repeated.
// Synchronous reset empties the pipeline; there is no other state.
// Zero-direction axes hit only when the origin lies inside the slab, and
// boxes behind the origin still report hits.
module ray_box_slab_test import rbs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  rbs_req_if.sink    ray,
  rbs_rsp_if.source  result
);

  logic   slab_valid;
  logic   slab_ready;
  slab_t  slab_data;
  logic   cross_valid;
  logic   cross_ready;
  cross_t cross_data;

  // plane offsets
  rbs_slab u_slab (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ray.valid),
    .in_ready  (ray.ready),
    .in_data   (ray.data),
    .out_valid (slab_valid),
    .out_ready (slab_ready),
    .out_data  (slab_data)
  );

  // cross products
  rbs_cross u_cross (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (slab_valid),
    .in_ready  (slab_ready),
    .in_data   (slab_data),
    .out_valid (cross_valid),
    .out_ready (cross_ready),
    .out_data  (cross_data)
  );

  // compares and output register
  rbs_decide u_decide (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cross_valid),
    .in_ready  (cross_ready),
    .in_data   (cross_data),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result.data)
  );

  // an open receiver never backs up the request side
  assert property (@(posedge clk) disable iff (rst) result.ready |-> ray.ready)
    else $error("request stalled while receiver is ready");

  // reset empties the output stage
  assert property (@(posedge clk) $past(rst) |-> !result.valid)
    else $error("result valid right after reset");

  // zero x direction with origin below the slab must come out as a miss
  assert property (@(posedge clk) disable iff (rst)
    (ray.valid && ray.ready && ray.data.ray_dir_x == '0
     && ray.data.ray_origin_x < ray.data.box_min_x)
    ##1 result.ready ##1 result.ready |=> result.valid && !result.data.hits_box)
    else $error("zero-direction slab miss lost");

  // empty middle stages leave the request side open
  assert property (@(posedge clk) disable iff (rst)
    (!slab_valid && !cross_valid) |-> ray.ready)
    else $error("request stalled with empty pipeline");

endmodule
